/* design/fce_pkg.sv */
// Shared constants and types for the feedback comb echo block.
package fce_pkg;

    // Depth of the output history and the widths that follow from it.
    localparam int MAX_DELAY = 16384;
    localparam int ADDR_W    = $clog2(MAX_DELAY);

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int DL_W       = 15;
    localparam int GAIN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Width of the delay arithmetic: holds both the register and twice the depth.
    localparam int D_W = (ADDR_W + 1 > DL_W) ? ADDR_W + 1 : DL_W;

    // Mixing arithmetic: two 8x16 signed products summed stay inside 24 bits.
    localparam int ACC_W = 24;
    localparam int MAG_W = ACC_W - 1;

    // Truncating division by 100 as a multiplication by a scaled reciprocal.
    // ceil(2^30 / 100); exact for every magnitude below 2^23.
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = 17;

    // Saturation limits as quotient magnitudes.
    localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAYED_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = 2'd2;

    // Register values after reset.
    localparam logic [DL_W-1:0]   DELAY_RST  = 15'd12288;
    localparam logic [GAIN_W-1:0] DGAIN_RST  = 7'd75;
    localparam logic [GAIN_W-1:0] IGAIN_RST  = 7'd25;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]          t_addr;

endpackage

/* design/fce_in_if.sv */
// Input sample channel: valid, ready and one signed sample.
interface fce_in_if import fce_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

/* design/fce_out_if.sv */
// Output sample channel: valid, ready and one signed sample.
interface fce_out_if import fce_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

/* design/fce_ram.sv */
// Generic single-write, single-read memory with a registered read port.
module fce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/feedback_comb_echo.sv */
// Top level of the feedback comb echo: history memory, mixing pipeline and output register.
//
// The block takes signed 16-bit samples on i_in and gives one echoed sample per
// transfer on o_out: y = (delayed_gain * y[n-D] + input_gain * x) / 100, the
// division truncating toward zero and the result saturated to 16 bits. Each
// result is also written into a history memory of MAX_DELAY entries, which
// supplies y[n-D] for later samples. D is delay_length, held between 1 and
// MAX_DELAY.
// Configuration must be written through i_cfg_we, i_cfg_idx and i_cfg_data while the
// block is idle (not enforced); indexes beyond the third register are ignored.
// An accepted sample passes through stages B, C and E into the output register.
// A new sample can be taken every cycle unless a stall or the interlock holds the
// input. The loop through the history memory (read, multiply-add, reciprocal
// multiply, write back) runs through stages B, C and E, so when D is below four
// an interlock holds the input until the entry it needs is written.
// After reset the registers take their default values and the history reads as
// zero; a flag tracks which entries have been written since, so no clearing pass
// is needed and samples are taken from the first cycle.
// When the receiver stalls, the output register holds its sample and the three
// stages behind it keep filling, so up to four samples are in flight before the
// input is held.
module feedback_comb_echo import fce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fce_in_if.sink                i_in,
    fce_out_if.source             o_out
);

    // Configuration registers.
    logic [DL_W-1:0]   r_delay_length;
    logic [GAIN_W-1:0] r_delayed_gain;
    logic [GAIN_W-1:0] r_input_gain;

    // Write pointer into the history and a flag set once it has wrapped.
    t_addr r_wr_slot;
    logic  r_wrapped;

    // Stage B: the memory read is under way and its data arrives in this stage.
    logic    r_b_v;
    logic    r_b_hv;
    t_sample r_b_sample;
    t_addr   r_b_slot;

    // Stage C: the mixed sum.
    logic                    r_c_v;
    logic signed [ACC_W-1:0] r_c_acc;
    t_addr                   r_c_slot;

    // Stage E: the reciprocal product; the result is written back from here.
    logic              r_e_v;
    logic              r_e_neg;
    logic [PROD_W-1:0] r_e_prod;
    t_addr             r_e_slot;

    // Output register.
    logic    r_out_v;
    t_sample r_out_sample;

    // Stage enables: a stage moves on when its successor is empty or moving.
    logic en_out, en_e, en_c, en_b;
    logic hazard;
    logic in_acc;

    // Read address for the arriving sample.
    logic [D_W-1:0] dl_ext;
    logic [D_W-1:0] d_eff;
    logic [D_W-1:0] slot_ext;
    logic [D_W-1:0] rd_ext;
    logic           hist_ok;
    t_addr          rd_addr;
    logic           last_slot;

    // Datapath between the stages.
    t_sample                 ram_q;
    t_sample                 b_hist;
    logic signed [ACC_W-1:0] b_acc;
    logic                    c_neg;
    logic [MAG_W-1:0]        c_mag;
    logic [PROD_W-1:0]       c_prod;
    logic [QUO_W-1:0]        e_quo;
    t_sample                 e_y;
    logic                    ram_we;

    // The delay is clamped to the depth of the history, and zero acts as one.
    always_comb begin
        dl_ext   = D_W'(r_delay_length);
        if (dl_ext == '0) begin
            d_eff = D_W'(1);
        end else if (dl_ext > D_W'(MAX_DELAY)) begin
            d_eff = D_W'(MAX_DELAY);
        end else begin
            d_eff = dl_ext;
        end
        slot_ext = D_W'(r_wr_slot);
        hist_ok  = slot_ext >= d_eff;
        rd_ext   = hist_ok ? slot_ext - d_eff : slot_ext + D_W'(MAX_DELAY) - d_eff;
        rd_addr  = rd_ext[ADDR_W-1:0];
    end

    assign last_slot = (r_wr_slot == ADDR_W'(MAX_DELAY - 1));

    // An entry whose result is still in the pipeline must not be read yet.
    assign hazard = (r_b_v && (r_b_slot == rd_addr))
                 || (r_c_v && (r_c_slot == rd_addr))
                 || (r_e_v && (r_e_slot == rd_addr));

    assign en_out = !r_out_v || o_out.ready;
    assign en_e   = !r_e_v || en_out;
    assign en_c   = !r_c_v || en_e;
    assign en_b   = !r_b_v || en_c;
    assign in_acc = i_in.valid && en_b && !hazard;
    assign ram_we = r_e_v && en_out;

    fce_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_e_slot),
        .i_wdata (e_y),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Entries not yet written since reset read as zero.
    always_comb begin
        b_hist = r_b_hv ? ram_q : '0;
        b_acc  = ACC_W'($signed({1'b0, r_delayed_gain})) * ACC_W'(b_hist)
               + ACC_W'($signed({1'b0, r_input_gain})) * ACC_W'(r_b_sample);
    end

    // Divide the magnitude, so that the quotient truncates toward zero.
    always_comb begin
        c_neg  = r_c_acc[ACC_W-1];
        c_mag  = MAG_W'(c_neg ? -r_c_acc : r_c_acc);
        c_prod = PROD_W'(c_mag) * PROD_W'(RECIP);
    end

    // Restore the sign and saturate to the sample range.
    always_comb begin
        e_quo = QUO_W'(r_e_prod >> RECIP_SHIFT);
        if (!r_e_neg) begin
            e_y = (e_quo > POS_LIMIT) ? SAMPLE_MAX : e_quo[SAMPLE_W-1:0];
        end else begin
            e_y = (e_quo > NEG_LIMIT) ? SAMPLE_MIN : -e_quo[SAMPLE_W-1:0];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= DELAY_RST;
            r_delayed_gain <= DGAIN_RST;
            r_input_gain   <= IGAIN_RST;
            r_wr_slot      <= '0;
            r_wrapped      <= 1'b0;
            r_b_v          <= 1'b0;
            r_c_v          <= 1'b0;
            r_e_v          <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DELAY_LENGTH: r_delay_length <= i_cfg_data[DL_W-1:0];
                    CFG_DELAYED_GAIN: r_delayed_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_INPUT_GAIN:   r_input_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_wr_slot <= last_slot ? '0 : r_wr_slot + ADDR_W'(1);
                if (last_slot) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (en_b) begin
                r_b_v <= in_acc;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
            if (en_e) begin
                r_e_v <= r_c_v;
            end
            if (en_out) begin
                r_out_v <= r_e_v;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_hv     <= r_wrapped || hist_ok;
            r_b_sample <= i_in.in_sample;
            r_b_slot   <= r_wr_slot;
        end
        if (en_c && r_b_v) begin
            r_c_acc  <= b_acc;
            r_c_slot <= r_b_slot;
        end
        if (en_e && r_c_v) begin
            r_e_neg  <= c_neg;
            r_e_prod <= c_prod;
            r_e_slot <= r_c_slot;
        end
        if (ram_we) begin
            r_out_sample <= e_y;
        end
    end

    assign i_in.ready       = en_b && !hazard;
    assign o_out.valid      = r_out_v;
    assign o_out.out_sample = r_out_sample;

    // An accepted sample always reaches the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_b_v)
        else $error("accepted sample did not enter the pipeline");

    // Every write back loads the output register.
    a_write_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_out_v)
        else $error("history write without an output sample");

    // Samples in stages B and E hold distinct history slots.
    a_distinct_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && r_e_v) |-> (r_b_slot != r_e_slot))
        else $error("two samples in flight share a history slot");

    // A sample is never accepted while the entry it reads is still pending in stage E.
    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_e_v) |-> (rd_addr != r_e_slot))
        else $error("history read overtook a pending write");

    // Reset empties the history pointer, clears the wrap flag and empties the output register.
    a_reset_slot: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_wr_slot == '0) && !r_wrapped && !r_out_v)
        else $error("reset did not clear the history pointer");

endmodule
